@@ design/bmgc_pkg.sv @@
// Package for the cached Box-Muller Gaussian sample source.
// Holds the shared result type, the fixed-point constants and the series tables.
// No dependencies.
package bmgc_pkg;

  localparam int UNIFORM_BITS  = 32;
  localparam int OUT_FRAC_BITS = 16;
  localparam int SAMPLE_BITS   = 24;
  localparam int SIGMA_BITS    = 16;

  localparam logic [SIGMA_BITS-1:0] SIGMA_RESET = 16'd4096;

  // ln(2) in Q.28 and pi/4 in Q.30.
  localparam logic [27:0] LN2_Q28        = 28'd186065280;
  localparam logic [29:0] QUARTER_PI_Q30 = 30'd843314857;
  localparam logic [30:0] ONE_Q30        = 31'h4000_0000;

  // Result of one fresh pair, plus the core's status.
  typedef struct packed {
    logic                          busy;
    logic                          done;
    logic signed [SAMPLE_BITS-1:0] cos_sample;
    logic signed [SAMPLE_BITS-1:0] sin_sample;
  } core_res_t;

  // Divisor of each Taylor term: four sine terms, then five cosine terms.
  function automatic logic [6:0] term_div(input logic [3:0] idx);
    logic [6:0] d;
    case (idx)
      4'd0:    d = 7'd6;
      4'd1:    d = 7'd20;
      4'd2:    d = 7'd42;
      4'd3:    d = 7'd72;
      4'd4:    d = 7'd2;
      4'd5:    d = 7'd12;
      4'd6:    d = 7'd30;
      4'd7:    d = 7'd56;
      4'd8:    d = 7'd90;
      default: d = 7'd2;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor) for each Taylor term.
  function automatic logic [31:0] term_recip(input logic [3:0] idx);
    logic [31:0] r;
    case (idx)
      4'd0:    r = 32'd715827882;
      4'd1:    r = 32'd214748364;
      4'd2:    r = 32'd102261126;
      4'd3:    r = 32'd59652323;
      4'd4:    r = 32'd2147483648;
      4'd5:    r = 32'd357913941;
      4'd6:    r = 32'd143165576;
      4'd7:    r = 32'd76695844;
      4'd8:    r = 32'd47721858;
      default: r = 32'd2147483648;
    endcase
    return r;
  endfunction

endpackage

@@ design/box_muller_gaussian_cached.sv @@
// Top level of the cached Box-Muller Gaussian sample source.
// Depends on bmgc_pkg and bmgc_core (which uses bmgc_mul).
//
// Each transfer on the uniform channel asks for one Gaussian sample. With the
// cache empty, the item's u_radius and u_angle start a fresh pair: the core
// normalizes u_radius with a binary shift search, takes log2 with 30 squaring
// rounds, scales to -2 ln(u), extracts the square root one bit per cycle,
// scales by sigma, reduces the angle to an octant and evaluates nine Taylor
// terms, each as a term multiply, a reciprocal multiply and a quotient fix-up,
// with the main products on one shared 32 x 32 multiplier. The uniform
// channel stalls for the whole fresh pair, whose length is set by the log and
// root loops and the series. The cosine sample comes out with fresh = 1 and
// the sine sample is kept; the next transfer then returns the kept sample
// (fresh = 0) without touching the uniforms. Results pass through a one-entry
// pending slot and an output register, so a new item is taken while a result
// waits to be taken downstream. Sigma is Q4.12 and may only be written while
// idle; a kept sample retains the sigma used when it was computed.
module box_muller_gaussian_cached (
  input  logic               clk,
  input  logic               rst,
  input  logic               sigma_we,
  input  logic [15:0]        sigma_wdata,
  input  logic               u_valid,
  output logic               u_stall,
  input  logic [31:0]        u_radius,
  input  logic [31:0]        u_angle,
  output logic               sample_valid,
  input  logic               sample_stall,
  output logic signed [23:0] sample,
  output logic               fresh
);

  logic [15:0]         sigma;
  logic                cache_full;
  logic signed [23:0]  cached_sample;
  logic                pend;
  logic signed [23:0]  pend_sample;
  logic                pend_fresh;
  logic                accept;
  logic                out_free;
  bmgc_pkg::core_res_t core_res;

  // The core is busy for a whole fresh pair; a pending result also holds the
  // uniform channel off, since it has nowhere else to go.
  assign u_stall  = core_res.busy || pend;
  assign accept   = u_valid && !u_stall;
  assign out_free = !sample_valid || !sample_stall;

  bmgc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && !cache_full),
    .u_radius (u_radius),
    .u_angle  (u_angle),
    .sigma    (sigma),
    .res      (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sigma         <= bmgc_pkg::SIGMA_RESET;
      cache_full    <= 1'b0;
      cached_sample <= 24'sd0;
      pend          <= 1'b0;
      sample_valid  <= 1'b0;
    end else begin
      if (sigma_we) begin
        sigma <= sigma_wdata;
      end
      // Move the pending result into the output register once it is free.
      if (out_free) begin
        sample_valid <= pend;
        if (pend) begin
          sample <= pend_sample;
          fresh  <= pend_fresh;
          pend   <= 1'b0;
        end
      end
      // A transfer with the cache full returns the kept sine sample.
      if (accept && cache_full) begin
        pend        <= 1'b1;
        pend_sample <= cached_sample;
        pend_fresh  <= 1'b0;
        cache_full  <= 1'b0;
      end
      // A finished pair delivers the cosine sample and keeps the sine sample.
      if (core_res.done) begin
        pend          <= 1'b1;
        pend_sample   <= core_res.cos_sample;
        pend_fresh    <= 1'b1;
        cached_sample <= core_res.sin_sample;
        cache_full    <= 1'b1;
      end
    end
  end

  a_done_slot_free: assert property (@(posedge clk) disable iff (rst)
    core_res.done |-> !pend)
    else $error("core finished while a result was still pending");

  a_busy_cache_empty: assert property (@(posedge clk) disable iff (rst)
    core_res.busy |-> !cache_full)
    else $error("core running while a sample is cached");

  a_cached_path: assert property (@(posedge clk) disable iff (rst)
    (accept && cache_full) |=> (pend && !pend_fresh && !cache_full))
    else $error("cached transfer did not return the kept sample");

  a_fresh_path: assert property (@(posedge clk) disable iff (rst)
    core_res.done |=> (cache_full && pend && pend_fresh))
    else $error("finished pair did not fill the cache and the pending slot");

endmodule

@@ design/bmgc_mul.sv @@
// Shared 32 x 32 unsigned multiplier of the Gaussian sample core.
// Purely combinational; the caller registers the product. Uses no package.
module bmgc_mul (
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  assign p = {32'd0, a} * {32'd0, b};

endmodule

@@ design/bmgc_core.sv @@
// Sequencer and datapath that turn two uniforms into a cosine and a sine sample.
// Depends on bmgc_pkg and on the shared multiplier bmgc_mul.
module bmgc_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [31:0]         u_radius,
  input  logic [31:0]         u_angle,
  input  logic [15:0]         sigma,
  output bmgc_pkg::core_res_t res
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_NORM  = 4'd1;
  localparam logic [3:0] S_LOG   = 4'd2;
  localparam logic [3:0] S_LNMUL = 4'd3;
  localparam logic [3:0] S_SQRT  = 4'd4;
  localparam logic [3:0] S_RMUL  = 4'd5;
  localparam logic [3:0] S_THMUL = 4'd6;
  localparam logic [3:0] S_T2MUL = 4'd7;
  localparam logic [3:0] S_TRMUL = 4'd8;
  localparam logic [3:0] S_TDIV  = 4'd9;
  localparam logic [3:0] S_TFIX  = 4'd10;
  localparam logic [3:0] S_OUTC  = 4'd11;
  localparam logic [3:0] S_OUTS  = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  localparam logic [30:0] ONE_Q30_L = bmgc_pkg::ONE_Q30;

  logic [3:0]         state;
  logic [4:0]         cnt;
  logic               m_zero;
  logic [31:0]        norm;
  logic [4:0]         shn;
  logic [30:0]        x;
  logic [29:0]        f;
  logic [61:0]        sq_v;
  logic [32:0]        sq_rem;
  logic [30:0]        root;
  logic [30:0]        rad;
  logic [31:0]        ang;
  logic [29:0]        th;
  logic [29:0]        t2;
  logic [30:0]        term;
  logic [30:0]        nv;
  logic [30:0]        q0;
  logic signed [32:0] acc;
  logic [30:0]        s0;
  logic [30:0]        c0;
  logic [23:0]        cos_out;
  logic [23:0]        sin_out;

  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        mul_p;

  logic [31:0]        norm_next;
  logic [4:0]         shn_next;
  logic [31:0]        sq;
  logic [5:0]         e_hi;
  logic [35:0]        e_val;
  logic [31:0]        e_top;
  logic [63:0]        ln_sum;
  logic [34:0]        rem_sh;
  logic [34:0]        trial;
  logic [34:0]        rem_diff;
  logic [2:0]         oct;
  logic [29:0]        gm;
  logic [3:0]         oct_p1;
  logic [3:0]         oct_p2;
  logic               swap;
  logic               cneg;
  logic               sneg;
  logic [30:0]        cv;
  logic [30:0]        sv;
  logic [6:0]         dv;
  logic [37:0]        qd;
  logic [30:0]        q;
  logic signed [32:0] acc_next;
  logic [30:0]        acc_clamp;
  logic [63:0]        rnd;
  logic [25:0]        mag;
  logic [23:0]        out_val;

  bmgc_mul u_mul (.a(mul_a), .b(mul_b), .p(mul_p));

  // Normalization: one stage of a binary shift search per cycle.
  always_comb begin
    norm_next = norm;
    shn_next  = shn;
    case (cnt[2:0])
      3'd0: begin
        if (norm[31:16] == 16'd0) begin
          norm_next = {norm[15:0], 16'd0};
          shn_next  = shn + 5'd16;
        end
      end
      3'd1: begin
        if (norm[31:24] == 8'd0) begin
          norm_next = {norm[23:0], 8'd0};
          shn_next  = shn + 5'd8;
        end
      end
      3'd2: begin
        if (norm[31:28] == 4'd0) begin
          norm_next = {norm[27:0], 4'd0};
          shn_next  = shn + 5'd4;
        end
      end
      3'd3: begin
        if (norm[31:30] == 2'd0) begin
          norm_next = {norm[29:0], 2'd0};
          shn_next  = shn + 5'd2;
        end
      end
      default: begin
        if (!norm[31]) begin
          norm_next = {norm[30:0], 1'b0};
          shn_next  = shn + 5'd1;
        end
      end
    endcase
  end

  always_comb begin
    sq       = mul_p[61:30];
    e_hi     = {1'b0, shn} + 6'd1;
    e_val    = m_zero ? 36'd0 : ({e_hi, 30'd0} - {6'd0, f});
    e_top    = {28'd0, e_val[35:32]} * {4'd0, bmgc_pkg::LN2_Q28};
    ln_sum   = mul_p + {e_top, 32'd0};
    rem_sh   = {sq_rem, sq_v[61:60]};
    trial    = {2'b00, root, 2'b01};
    rem_diff = rem_sh - trial;
    oct      = ang[31:29];
    gm       = oct[0] ? (30'h2000_0000 - {1'b0, ang[28:0]}) : {1'b0, ang[28:0]};
    oct_p1   = {1'b0, oct} + 4'd1;
    oct_p2   = {1'b0, oct} + 4'd2;
    swap     = oct_p1[1];
    cneg     = oct_p2[2];
    sneg     = oct[2];
    cv       = swap ? s0 : c0;
    sv       = swap ? c0 : s0;
    dv       = bmgc_pkg::term_div(cnt[3:0]);
    qd       = {7'd0, q0} * {31'd0, dv};
    q        = ({7'd0, nv} >= (qd + {31'd0, dv})) ? (q0 + 31'd1) : q0;
    acc_next = cnt[0] ? (acc + $signed({2'b00, q})) : (acc - $signed({2'b00, q}));
    acc_clamp = acc_next[32] ? 31'd0 : acc_next[30:0];
    // Round half up on the magnitude, then saturate to the signed range.
    rnd      = mul_p + 64'h0000_0020_0000_0000;
    mag      = rnd[63:38];
    out_val  = 24'd0;
    if (state == S_OUTC ? cneg : sneg) begin
      out_val = (mag > 26'd8388608) ? 24'h80_0000 : 24'(26'd0 - mag);
    end else begin
      out_val = (mag > 26'd8388607) ? 24'h7F_FFFF : mag[23:0];
    end
  end

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state)
      S_LOG: begin
        mul_a = {1'b0, x};
        mul_b = {1'b0, x};
      end
      S_LNMUL: begin
        mul_a = e_val[31:0];
        mul_b = {4'd0, bmgc_pkg::LN2_Q28};
      end
      S_RMUL: begin
        mul_a = {1'b0, root};
        mul_b = {16'd0, sigma};
      end
      S_THMUL: begin
        mul_a = {2'd0, gm};
        mul_b = {2'd0, bmgc_pkg::QUARTER_PI_Q30};
      end
      S_T2MUL: begin
        mul_a = {2'd0, th};
        mul_b = {2'd0, th};
      end
      S_TRMUL: begin
        mul_a = {1'b0, term};
        mul_b = {2'd0, t2};
      end
      S_TDIV: begin
        mul_a = {1'b0, nv};
        mul_b = bmgc_pkg::term_recip(cnt[3:0]);
      end
      S_OUTC: begin
        mul_a = {1'b0, rad};
        mul_b = {1'b0, cv};
      end
      S_OUTS: begin
        mul_a = {1'b0, rad};
        mul_b = {1'b0, sv};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= 5'd0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            norm   <= u_radius;
            ang    <= u_angle;
            m_zero <= (u_radius == 32'd0);
            shn    <= 5'd0;
            cnt    <= 5'd0;
            state  <= S_NORM;
          end
        end
        S_NORM: begin
          norm <= norm_next;
          shn  <= shn_next;
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd4) begin
            x     <= norm_next[31:1];
            f     <= 30'd0;
            cnt   <= 5'd1;
            state <= S_LOG;
          end
        end
        S_LOG: begin
          if (sq[31]) begin
            x                <= sq[31:1];
            f[5'd30 - cnt]   <= 1'b1;
          end else begin
            x <= sq[30:0];
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd30) begin
            state <= S_LNMUL;
          end
        end
        S_LNMUL: begin
          sq_v   <= {ln_sum[62:27], 26'd0};
          sq_rem <= 33'd0;
          root   <= 31'd0;
          cnt    <= 5'd0;
          state  <= S_SQRT;
        end
        S_SQRT: begin
          if (rem_sh >= trial) begin
            sq_rem <= rem_diff[32:0];
            root   <= {root[29:0], 1'b1};
          end else begin
            sq_rem <= rem_sh[32:0];
            root   <= {root[29:0], 1'b0};
          end
          sq_v <= {sq_v[59:0], 2'b00};
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd30) begin
            state <= S_RMUL;
          end
        end
        S_RMUL: begin
          rad   <= mul_p[46:16];
          state <= S_THMUL;
        end
        S_THMUL: begin
          th    <= mul_p[58:29];
          state <= S_T2MUL;
        end
        S_T2MUL: begin
          t2    <= mul_p[59:30];
          term  <= {1'b0, th};
          acc   <= $signed({3'b000, th});
          cnt   <= 5'd0;
          state <= S_TRMUL;
        end
        S_TRMUL: begin
          nv    <= mul_p[60:30];
          state <= S_TDIV;
        end
        S_TDIV: begin
          q0    <= mul_p[62:32];
          state <= S_TFIX;
        end
        S_TFIX: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd3) begin
            s0    <= acc_clamp;
            term  <= ONE_Q30_L;
            acc   <= $signed({2'b00, ONE_Q30_L});
            state <= S_TRMUL;
          end else if (cnt == 5'd8) begin
            c0    <= acc_clamp;
            state <= S_OUTC;
          end else begin
            term  <= q;
            acc   <= acc_next;
            state <= S_TRMUL;
          end
        end
        S_OUTC: begin
          cos_out <= out_val;
          state   <= S_OUTS;
        end
        S_OUTS: begin
          sin_out <= out_val;
          state   <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res.busy       = (state != S_IDLE);
  assign res.done       = (state == S_DONE);
  assign res.cos_sample = $signed(cos_out);
  assign res.sin_sample = $signed(sin_out);

endmodule
